@@ rtl/core/alm_pkg.sv @@
package alm_pkg;

   // Default number of nodes in the store.
   localparam int CAPACITY_DEF = 128;

   // Beat widths on the two stream channels.
   localparam int REQ_DATA_W = 80;
   localparam int RSP_DATA_W = 80;

   // Operation codes.
   localparam logic [2:0] OP_APPEND  = 3'd0;
   localparam logic [2:0] OP_INSERT  = 3'd1;
   localparam logic [2:0] OP_DEL_POS = 3'd2;
   localparam logic [2:0] OP_DEL_KEY = 3'd3;
   localparam logic [2:0] OP_SEARCH  = 3'd4;
   localparam logic [2:0] OP_READ    = 3'd5;

   // Result status codes.
   localparam logic [1:0] ST_DONE     = 2'd0;
   localparam logic [1:0] ST_APPENDED = 2'd1;
   localparam logic [1:0] ST_FULL     = 2'd2;
   localparam logic [1:0] ST_NONE     = 2'd3;

   // Write enables of the node store.
   typedef struct packed {
      logic data_we;
      logic link_we;
   } alm_wr_ctl_type;

endpackage

@@ rtl/core/alm_store.sv @@
// Node store: key, payload and link memories with one write and one
// registered read port.
module alm_store #(
   parameter int CAPACITY = alm_pkg::CAPACITY_DEF,
   localparam int A_W = $clog2(CAPACITY),
   localparam int L_W = $clog2(CAPACITY + 1)
) (
   input  logic                         clock,
   input  alm_pkg::alm_wr_ctl_type      wr_ctl,
   input  logic [A_W-1:0]               wr_addr,
   input  logic signed [31:0]           wr_key,
   input  logic [31:0]                  wr_payload,
   input  logic [L_W-1:0]               wr_link,
   input  logic [A_W-1:0]               rd_addr,
   output logic signed [31:0]           rd_key,
   output logic [31:0]                  rd_payload,
   output logic [L_W-1:0]               rd_link
);

   logic signed [31:0] key_mem [CAPACITY];
   logic [31:0]        pay_mem [CAPACITY];
   logic [L_W-1:0]     link_mem [CAPACITY];

   always_ff @(posedge clock) begin
      if (wr_ctl.data_we) begin
         key_mem[wr_addr] <= wr_key;
         pay_mem[wr_addr] <= wr_payload;
      end
      if (wr_ctl.link_we) begin
         link_mem[wr_addr] <= wr_link;
      end
   end

   always_ff @(posedge clock) begin
      rd_key     <= key_mem[rd_addr];
      rd_payload <= pay_mem[rd_addr];
      rd_link    <= link_mem[rd_addr];
   end

endmodule

@@ rtl/core/array_linked_list_manager.sv @@
// Ordered list of key/payload entries held in a store of CAPACITY nodes,
// chained by next links, with unused nodes chained on a free list. Each
// request beat carries one operation (append, insert at a 1-based position,
// delete at a position, delete every entry with a key, search for a key,
// read at a position) and produces exactly one response beat with the
// status, the entry found, the entry count and the empty and full flags.
// A single sequencer drives one read and one write port of the node store
// and follows the links one node per clock cycle, so an operation takes
// longer the more nodes it has to pass: positional operations walk up to
// their position, while an append, a search or a key delete may walk the
// whole list. Only one request is in flight; the next one is taken once
// the block is idle and the response register is free or being drained.
// After reset the block builds the free chain in S_INIT before it accepts
// the first request.
module array_linked_list_manager #(
   parameter int CAPACITY = alm_pkg::CAPACITY_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [2:0] operation, [34:3] key, [66:35] payload, [74:67] position,
   // [79:75] zero
   input  logic [alm_pkg::REQ_DATA_W-1:0]  req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [1:0] status, [33:2] found_key, [65:34] found_payload,
   // [73:66] entry_count, [74] is_empty, [75] is_full, [79:76] zero
   output logic [alm_pkg::RSP_DATA_W-1:0]  rsp_tdata
);

   localparam int A_W = $clog2(CAPACITY);
   localparam int L_W = $clog2(CAPACITY + 1);
   localparam int CW  = (L_W > 8) ? L_W : 8;
   localparam logic [L_W-1:0] NIL = L_W'(CAPACITY);
   localparam logic [L_W-1:0] LAST_STEP = L_W'(CAPACITY - 1);

   localparam logic [3:0] S_INIT = 4'd0;
   localparam logic [3:0] S_IDLE = 4'd1;
   localparam logic [3:0] S_TAKE = 4'd2;
   localparam logic [3:0] S_SEEK = 4'd3;
   localparam logic [3:0] S_LINK = 4'd4;
   localparam logic [3:0] S_INSL = 4'd5;
   localparam logic [3:0] S_DLN  = 4'd6;
   localparam logic [3:0] S_DH   = 4'd7;
   localparam logic [3:0] S_FREE = 4'd8;
   localparam logic [3:0] S_RDAT = 4'd9;
   localparam logic [3:0] S_SRCH = 4'd10;
   localparam logic [3:0] S_KEV  = 4'd11;
   localparam logic [3:0] S_KFR  = 4'd12;
   localparam logic [3:0] S_DONE = 4'd13;

   // Sequencer and list state.
   logic [3:0]     state_ff, state_in;
   logic [L_W-1:0] init_ff, init_in;
   logic [L_W-1:0] head_ff, head_in;
   logic [L_W-1:0] free_ff, free_in;
   logic [L_W-1:0] count_ff, count_in;
   logic           rsp_valid_ff, rsp_valid_in;

   // Working registers of the operation in progress.
   logic [2:0]         op_ff, op_in;
   logic signed [31:0] key_ff, key_in;
   logic [31:0]        pay_ff, pay_in;
   logic [7:0]         pos_ff, pos_in;
   logic [L_W-1:0]     p_ff, p_in;
   logic [L_W-1:0]     prev_ff, prev_in;
   logic [L_W-1:0]     n_ff, n_in;
   logic [CW-1:0]      rem_ff, rem_in;
   logic [L_W-1:0]     steps_ff, steps_in;
   logic               rv_ff, rv_in;
   logic               hit_ff, hit_in;
   logic               apnd_ff, apnd_in;
   logic [1:0]         status_ff, status_in;
   logic signed [31:0] fk_ff, fk_in;
   logic [31:0]        fp_ff, fp_in;
   logic [alm_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   // Node store ports.
   alm_pkg::alm_wr_ctl_type wr_ctl;
   logic [A_W-1:0]     wr_addr;
   logic signed [31:0] wr_key;
   logic [31:0]        wr_payload;
   logic [L_W-1:0]     wr_link;
   logic [A_W-1:0]     rd_addr;
   logic signed [31:0] rd_key;
   logic [31:0]        rd_payload;
   logic [L_W-1:0]     rd_link;

   // Request fields.
   logic [2:0]         req_op;
   logic signed [31:0] req_key;
   logic [31:0]        req_pay;
   logic [7:0]         req_pos;
   logic [7:0]         req_pos_c;
   logic [CW-1:0]      pos_w;
   logic [CW-1:0]      cnt_w;
   logic               is_full;
   logic               past_end;
   logic               link_ok;

   assign req_op    = req_tdata[2:0];
   assign req_key   = req_tdata[34:3];
   assign req_pay   = req_tdata[66:35];
   assign req_pos   = req_tdata[74:67];
   // A position of zero counts as the first position.
   assign req_pos_c = (req_pos == 8'd0) ? 8'd1 : req_pos;
   assign pos_w     = CW'(pos_ff);
   assign cnt_w     = CW'(count_ff);
   assign is_full   = (count_ff == NIL);
   assign past_end  = (CW'(req_pos_c) > cnt_w);
   // The walk goes on while the next link points at a node and the step
   // limit has not been reached.
   assign link_ok   = (rd_link < NIL) && (steps_ff != LAST_STEP);

   assign req_tready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   alm_store #(
      .CAPACITY (CAPACITY)
   ) u_store (
      .clock      (clock),
      .wr_ctl     (wr_ctl),
      .wr_addr    (wr_addr),
      .wr_key     (wr_key),
      .wr_payload (wr_payload),
      .wr_link    (wr_link),
      .rd_addr    (rd_addr),
      .rd_key     (rd_key),
      .rd_payload (rd_payload),
      .rd_link    (rd_link)
   );

   always_comb begin
      state_in     = state_ff;
      init_in      = init_ff;
      head_in      = head_ff;
      free_in      = free_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      op_in        = op_ff;
      key_in       = key_ff;
      pay_in       = pay_ff;
      pos_in       = pos_ff;
      p_in         = p_ff;
      prev_in      = prev_ff;
      n_in         = n_ff;
      rem_in       = rem_ff;
      steps_in     = steps_ff;
      rv_in        = rv_ff;
      hit_in       = hit_ff;
      apnd_in      = apnd_ff;
      status_in    = status_ff;
      fk_in        = fk_ff;
      fp_in        = fp_ff;
      rsp_data_in  = rsp_data_ff;
      wr_ctl       = '0;
      wr_addr      = p_ff[A_W-1:0];
      wr_key       = key_ff;
      wr_payload   = pay_ff;
      wr_link      = free_ff;
      rd_addr      = p_ff[A_W-1:0];

      unique case (state_ff)
         S_INIT: begin
            // Chain every node to the next one; the last links to null.
            wr_ctl.link_we = 1'b1;
            wr_addr        = init_ff[A_W-1:0];
            wr_link        = init_ff + 1'b1;
            init_in        = init_ff + 1'b1;
            if (init_ff == LAST_STEP) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_tvalid && req_tready) begin
               op_in     = req_op;
               key_in    = req_key;
               pay_in    = req_pay;
               pos_in    = req_pos_c;
               status_in = alm_pkg::ST_DONE;
               fk_in     = '0;
               fp_in     = '0;
               apnd_in   = 1'b0;
               rv_in     = 1'b0;
               hit_in    = 1'b0;
               p_in      = head_ff;
               prev_in   = NIL;
               steps_in  = '0;
               state_in  = S_DONE;
               unique case (req_op)
                  alm_pkg::OP_APPEND: begin
                     if (is_full) begin
                        status_in = alm_pkg::ST_FULL;
                     end else begin
                        rd_addr  = free_ff[A_W-1:0];
                        n_in     = free_ff;
                        state_in = S_TAKE;
                     end
                  end
                  alm_pkg::OP_INSERT: begin
                     if (is_full) begin
                        status_in = alm_pkg::ST_FULL;
                     end else begin
                        if (past_end) begin
                           apnd_in   = 1'b1;
                           status_in = alm_pkg::ST_APPENDED;
                        end
                        rd_addr  = free_ff[A_W-1:0];
                        n_in     = free_ff;
                        state_in = S_TAKE;
                     end
                  end
                  alm_pkg::OP_DEL_POS: begin
                     if (past_end) begin
                        status_in = alm_pkg::ST_NONE;
                     end else if (req_pos_c == 8'd1) begin
                        rd_addr  = head_ff[A_W-1:0];
                        state_in = S_DH;
                     end else begin
                        rem_in   = CW'(req_pos_c) - CW'(2);
                        state_in = S_SEEK;
                     end
                  end
                  alm_pkg::OP_DEL_KEY: begin
                     if (head_ff == NIL) begin
                        status_in = alm_pkg::ST_NONE;
                     end else begin
                        rd_addr  = head_ff[A_W-1:0];
                        state_in = S_KEV;
                     end
                  end
                  alm_pkg::OP_SEARCH: begin
                     status_in = alm_pkg::ST_NONE;
                     if (head_ff != NIL) begin
                        rd_addr  = head_ff[A_W-1:0];
                        state_in = S_SRCH;
                     end
                  end
                  alm_pkg::OP_READ: begin
                     if (past_end) begin
                        status_in = alm_pkg::ST_NONE;
                     end else begin
                        rem_in   = CW'(req_pos_c) - CW'(1);
                        state_in = S_SEEK;
                     end
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_TAKE: begin
            // The free node's link becomes the new head of the free chain.
            free_in        = rd_link;
            wr_ctl.data_we = 1'b1;
            wr_addr        = n_ff[A_W-1:0];
            p_in           = head_ff;
            rv_in          = 1'b0;
            if (op_ff == alm_pkg::OP_APPEND || apnd_ff) begin
               wr_ctl.link_we = 1'b1;
               wr_link        = NIL;
               if (count_ff == '0) begin
                  head_in  = n_ff;
                  count_in = count_ff + 1'b1;
                  state_in = S_DONE;
               end else begin
                  rem_in   = cnt_w - CW'(1);
                  state_in = S_SEEK;
               end
            end else if (pos_ff == 8'd1) begin
               wr_ctl.link_we = 1'b1;
               wr_link        = head_ff;
               head_in        = n_ff;
               count_in       = count_ff + 1'b1;
               state_in       = S_DONE;
            end else begin
               rem_in   = pos_w - CW'(2);
               state_in = S_SEEK;
            end
         end
         S_SEEK: begin
            if (rem_ff == '0) begin
               priority if (op_ff == alm_pkg::OP_INSERT && !apnd_ff) begin
                  state_in = S_LINK;
               end else if (op_ff == alm_pkg::OP_DEL_POS) begin
                  prev_in  = p_ff;
                  state_in = S_LINK;
               end else if (op_ff == alm_pkg::OP_READ) begin
                  state_in = S_RDAT;
               end else begin
                  // Append: hook the new node behind the tail.
                  wr_ctl.link_we = 1'b1;
                  wr_link        = n_ff;
                  count_in       = count_ff + 1'b1;
                  state_in       = S_DONE;
               end
            end else if (!rv_ff) begin
               rv_in = 1'b1;
            end else begin
               p_in   = rd_link;
               rem_in = rem_ff - 1'b1;
               if (rem_ff != CW'(1)) begin
                  rd_addr = rd_link[A_W-1:0];
                  rv_in   = 1'b1;
               end else begin
                  rv_in = 1'b0;
               end
            end
         end
         S_LINK: begin
            if (op_ff == alm_pkg::OP_INSERT) begin
               wr_ctl.link_we = 1'b1;
               wr_addr        = n_ff[A_W-1:0];
               wr_link        = rd_link;
               state_in       = S_INSL;
            end else begin
               n_in     = rd_link;
               rd_addr  = rd_link[A_W-1:0];
               state_in = S_DLN;
            end
         end
         S_INSL: begin
            wr_ctl.link_we = 1'b1;
            wr_link        = n_ff;
            count_in       = count_ff + 1'b1;
            state_in       = S_DONE;
         end
         S_DLN: begin
            wr_ctl.link_we = 1'b1;
            wr_addr        = prev_ff[A_W-1:0];
            wr_link        = rd_link;
            state_in       = S_FREE;
         end
         S_DH: begin
            head_in  = rd_link;
            n_in     = p_ff;
            state_in = S_FREE;
         end
         S_FREE: begin
            wr_ctl.link_we = 1'b1;
            wr_addr        = n_ff[A_W-1:0];
            wr_link        = free_ff;
            free_in        = n_ff;
            count_in       = count_ff - 1'b1;
            state_in       = S_DONE;
         end
         S_RDAT: begin
            fk_in    = rd_key;
            fp_in    = rd_payload;
            state_in = S_DONE;
         end
         S_SRCH: begin
            if (rd_key == key_ff) begin
               fk_in     = rd_key;
               fp_in     = rd_payload;
               status_in = alm_pkg::ST_DONE;
               state_in  = S_DONE;
            end else if (link_ok) begin
               rd_addr  = rd_link[A_W-1:0];
               p_in     = rd_link;
               steps_in = steps_ff + 1'b1;
            end else begin
               state_in = S_DONE;
            end
         end
         S_KEV: begin
            p_in = rd_link;
            if (rd_key == key_ff) begin
               // Unhook the matching node; it goes to the free chain next.
               hit_in = 1'b1;
               n_in   = p_ff;
               if (prev_ff == NIL) begin
                  head_in = rd_link;
               end else begin
                  wr_ctl.link_we = 1'b1;
                  wr_addr        = prev_ff[A_W-1:0];
                  wr_link        = rd_link;
               end
               state_in = S_KFR;
            end else begin
               prev_in = p_ff;
               if (link_ok) begin
                  rd_addr  = rd_link[A_W-1:0];
                  steps_in = steps_ff + 1'b1;
               end else begin
                  status_in = hit_ff ? alm_pkg::ST_DONE : alm_pkg::ST_NONE;
                  state_in  = S_DONE;
               end
            end
         end
         S_KFR: begin
            wr_ctl.link_we = 1'b1;
            wr_addr        = n_ff[A_W-1:0];
            wr_link        = free_ff;
            free_in        = n_ff;
            if (count_ff != '0) begin
               count_in = count_ff - 1'b1;
            end
            if ((p_ff < NIL) && (steps_ff != LAST_STEP)) begin
               steps_in = steps_ff + 1'b1;
               state_in = S_KEV;
            end else begin
               status_in = alm_pkg::ST_DONE;
               state_in  = S_DONE;
            end
         end
         S_DONE: begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = {4'b0000,
                            (count_ff == NIL),
                            (count_ff == '0),
                            8'(count_ff),
                            fp_ff,
                            fk_ff,
                            status_ff};
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         init_ff      <= '0;
         head_ff      <= NIL;
         free_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         rv_ff        <= 1'b0;
         hit_ff       <= 1'b0;
         apnd_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         init_ff      <= init_in;
         head_ff      <= head_in;
         free_ff      <= free_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         rv_ff        <= rv_in;
         hit_ff       <= hit_in;
         apnd_ff      <= apnd_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      key_ff      <= key_in;
      pay_ff      <= pay_in;
      pos_ff      <= pos_in;
      p_ff        <= p_in;
      prev_ff     <= prev_in;
      n_ff        <= n_in;
      rem_ff      <= rem_in;
      steps_ff    <= steps_in;
      status_ff   <= status_in;
      fk_ff       <= fk_in;
      fp_ff       <= fp_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

@@ sim/list_checker.sv @@
`timescale 1ns / 100ps

module list_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [alm_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [alm_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output int                              mismatches,
   output int                              awaiting,
   output int                              list_len
);

   typedef struct {
      logic [31:0] key;
      logic [31:0] payload;
   } entry_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] found_key;
      logic [31:0] found_payload;
      logic [7:0]  entry_count;
      logic        is_empty;
      logic        is_full;
   } list_result_type;

   // The ordered list as the block should hold it, front entry first.
   entry_type       entries[$];
   list_result_type pending_results[$];

   function automatic list_result_type apply_list_op(input logic [2:0] op,
                                                     input logic [31:0] k,
                                                     input logic [31:0] pl,
                                                     input logic [7:0] pos_in);
      list_result_type r;
      entry_type       e;
      int              pos;
      int              hits;
      bit              seen;
      r = '0;
      e.key = k;
      e.payload = pl;
      pos = (pos_in == 0) ? 1 : int'(pos_in);
      hits = 0;
      seen = 0;
      case (op)
         alm_pkg::OP_APPEND: begin
            if (entries.size() >= alm_pkg::CAPACITY_DEF) r.status = alm_pkg::ST_FULL;
            else entries.push_back(e);
         end
         alm_pkg::OP_INSERT: begin
            if (entries.size() >= alm_pkg::CAPACITY_DEF) begin
               r.status = alm_pkg::ST_FULL;
            end else if (pos > entries.size()) begin
               entries.push_back(e);
               r.status = alm_pkg::ST_APPENDED;
            end else begin
               entries.insert(pos - 1, e);
            end
         end
         alm_pkg::OP_DEL_POS: begin
            if (pos > entries.size()) r.status = alm_pkg::ST_NONE;
            else entries.delete(pos - 1);
         end
         alm_pkg::OP_DEL_KEY: begin
            for (int i = entries.size() - 1; i >= 0; i--) begin
               if (entries[i].key == k) begin
                  entries.delete(i);
                  hits++;
               end
            end
            if (hits == 0) r.status = alm_pkg::ST_NONE;
         end
         alm_pkg::OP_SEARCH: begin
            r.status = alm_pkg::ST_NONE;
            for (int i = 0; i < entries.size(); i++) begin
               if (!seen && entries[i].key == k) begin
                  seen = 1;
                  r.status = alm_pkg::ST_DONE;
                  r.found_key = entries[i].key;
                  r.found_payload = entries[i].payload;
               end
            end
         end
         alm_pkg::OP_READ: begin
            if (pos > entries.size()) begin
               r.status = alm_pkg::ST_NONE;
            end else begin
               r.found_key = entries[pos - 1].key;
               r.found_payload = entries[pos - 1].payload;
            end
         end
         default: ;
      endcase
      r.entry_count = 8'(entries.size());
      r.is_empty = (entries.size() == 0);
      r.is_full = (entries.size() >= alm_pkg::CAPACITY_DEF);
      return r;
   endfunction

   function automatic void check_field(input string name, input logic [31:0] exp_v,
                                       input logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s: expected %h, got %h", name, exp_v, act_v);
         mismatches++;
      end
   endfunction

   initial begin
      mismatches = 0;
      awaiting = 0;
      list_len = 0;
   end

   always @(posedge clock) begin
      list_result_type want;
      if (!reset) begin
         // A response is checked before the request of the same edge is
         // predicted, since it can only belong to an earlier beat.
         if (rsp_tvalid && rsp_tready) begin
            if (pending_results.size() == 0) begin
               $error("response beat with no request outstanding");
               mismatches++;
            end else begin
               want = pending_results.pop_front();
               check_field("status",        want.status,        rsp_tdata[1:0]);
               check_field("found_key",     want.found_key,     rsp_tdata[33:2]);
               check_field("found_payload", want.found_payload, rsp_tdata[65:34]);
               check_field("entry_count",   want.entry_count,   rsp_tdata[73:66]);
               check_field("is_empty",      want.is_empty,      rsp_tdata[74]);
               check_field("is_full",       want.is_full,       rsp_tdata[75]);
            end
         end
         if (req_tvalid && req_tready)
            pending_results.push_back(apply_list_op(req_tdata[2:0], req_tdata[34:3],
                                                    req_tdata[66:35], req_tdata[74:67]));
         awaiting = pending_results.size();
         list_len = entries.size();
      end
   end

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 100ps

module tb;

   localparam int CYCLE_LIMIT = 3000000;

   logic                           clock;
   logic                           reset;
   logic                           req_tvalid;
   logic                           req_tready;
   logic [alm_pkg::REQ_DATA_W-1:0] req_tdata;
   logic                           rsp_tvalid;
   logic                           rsp_tready;
   logic [alm_pkg::RSP_DATA_W-1:0] rsp_tdata;

   int mismatches;
   int awaiting;
   int list_len;
   int cycles = 0;
   // While calm is set neither side idles, so back-to-back beats are seen.
   bit calm = 0;
   int stall_left = 0;

   array_linked_list_manager dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   list_checker chk (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .mismatches (mismatches),
      .awaiting   (awaiting),
      .list_len   (list_len)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   // The run is cut short at a hard limit on its length, which also catches a block that stops making progress.
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // The receiver mostly accepts at once, but now and then holds off
   // briefly, and rarely for a long stretch.
   always @(negedge clock) begin
      int  pick;
      logic ready_next;
      ready_next = 1'b1;
      if (!reset && !calm) begin
         if (stall_left > 0) begin
            stall_left--;
            ready_next = 1'b0;
         end else begin
            pick = $urandom_range(0, 99);
            if (pick >= 96) begin
               stall_left = $urandom_range(15, 60);
               ready_next = 1'b0;
            end else if (pick >= 70) begin
               stall_left = $urandom_range(0, 3);
               ready_next = 1'b0;
            end
         end
      end
      rsp_tready = ready_next;
   end

   // Presents one beat from a falling edge, holds it until the block takes
   // it, then leaves a random gap. With no gap tvalid simply stays high.
   task automatic send_beat(input logic [2:0] op, input logic [31:0] k,
                            input logic [31:0] pl, input logic [7:0] pos);
      int pick;
      int gap;
      req_tdata = {5'b0, pos, pl, k, op};
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      pick = $urandom_range(0, 99);
      if (calm || pick < 55) gap = 0;
      else if (pick < 93) gap = $urandom_range(1, 3);
      else gap = $urandom_range(10, 50);
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // Keys come mostly from a small pool so that searches and key deletes
   // find duplicates; the rest cover the whole 32-bit range.
   function automatic logic [31:0] pick_key();
      if ($urandom_range(0, 99) < 70) return $urandom_range(0, 7);
      return $urandom;
   endfunction

   function automatic logic [7:0] pick_position();
      if ($urandom_range(0, 99) < 80) return 8'($urandom_range(0, list_len + 2));
      return 8'($urandom_range(0, 255));
   endfunction

   // Weighted choice of operation: grow favours appends and inserts,
   // shrink favours the two kinds of delete, anything else is balanced.
   function automatic logic [2:0] pick_op(input int mood);
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 2) return 3'($urandom_range(6, 7));
      case (mood)
         0: begin
            if (pick < 45) return alm_pkg::OP_APPEND;
            if (pick < 80) return alm_pkg::OP_INSERT;
            if (pick < 85) return alm_pkg::OP_DEL_POS;
            if (pick < 88) return alm_pkg::OP_DEL_KEY;
            if (pick < 94) return alm_pkg::OP_SEARCH;
            return alm_pkg::OP_READ;
         end
         1: begin
            if (pick < 8) return alm_pkg::OP_APPEND;
            if (pick < 15) return alm_pkg::OP_INSERT;
            if (pick < 55) return alm_pkg::OP_DEL_POS;
            if (pick < 75) return alm_pkg::OP_DEL_KEY;
            if (pick < 88) return alm_pkg::OP_SEARCH;
            return alm_pkg::OP_READ;
         end
         default: return 3'($urandom_range(0, 5));
      endcase
   endfunction

   initial begin
      int sent;
      int mood;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part: every operation but insert on the empty list, the unknown
      // codes, extreme keys and payloads, position zero and positions past
      // the end, and a key delete that removes several entries at once.
      send_beat(alm_pkg::OP_READ,    32'd0,          32'd0,          8'd0);
      send_beat(alm_pkg::OP_DEL_POS, 32'd0,          32'd0,          8'd0);
      send_beat(alm_pkg::OP_DEL_KEY, 32'd5,          32'd0,          8'd1);
      send_beat(alm_pkg::OP_SEARCH,  32'd5,          32'd0,          8'd1);
      send_beat(3'd6,                32'hFFFF_FFFF,  32'hFFFF_FFFF,  8'hFF);
      send_beat(3'd7,                32'd1,          32'd1,          8'd1);
      send_beat(alm_pkg::OP_APPEND,  32'h8000_0000,  32'd0,          8'd0);
      send_beat(alm_pkg::OP_APPEND,  32'h7FFF_FFFF,  32'hFFFF_FFFF,  8'd0);
      send_beat(alm_pkg::OP_INSERT,  32'd5,          32'hA5A5_A5A5,  8'd0);
      send_beat(alm_pkg::OP_INSERT,  32'd5,          32'h5A5A_5A5A,  8'hFF);
      send_beat(alm_pkg::OP_INSERT,  32'hFFFF_FFFF,  32'h1234_5678,  8'd2);
      send_beat(alm_pkg::OP_READ,    32'd0,          32'd0,          8'd0);
      send_beat(alm_pkg::OP_READ,    32'd0,          32'd0,          8'hFF);
      send_beat(alm_pkg::OP_READ,    32'd0,          32'd0,          8'd3);
      send_beat(alm_pkg::OP_SEARCH,  32'h7FFF_FFFF,  32'd0,          8'd0);
      send_beat(alm_pkg::OP_SEARCH,  32'd99,         32'd0,          8'd0);
      send_beat(alm_pkg::OP_DEL_KEY, 32'd5,          32'd0,          8'd0);
      send_beat(alm_pkg::OP_DEL_KEY, 32'd5,          32'd0,          8'd0);
      send_beat(alm_pkg::OP_DEL_POS, 32'd0,          32'd0,          8'hFF);
      send_beat(alm_pkg::OP_DEL_POS, 32'd0,          32'd0,          8'd0);
      send_beat(alm_pkg::OP_DEL_POS, 32'd0,          32'd0,          8'd2);
      send_beat(alm_pkg::OP_READ,    32'd0,          32'd0,          8'd1);

      // The sender holds back once until every response is in.
      req_tvalid = 1'b0;
      while (awaiting != 0) @(negedge clock);

      // Fill the store completely, then hit it with appends and inserts
      // that must be refused, then read the far end of the list.
      while (list_len < alm_pkg::CAPACITY_DEF)
         send_beat(alm_pkg::OP_APPEND, pick_key(), $urandom, pick_position());
      send_beat(alm_pkg::OP_APPEND, pick_key(), $urandom, 8'd1);
      send_beat(alm_pkg::OP_INSERT, pick_key(), $urandom, 8'd1);
      send_beat(alm_pkg::OP_INSERT, pick_key(), $urandom, 8'hFF);
      send_beat(alm_pkg::OP_READ,   32'd0,      32'd0,   8'd128);
      send_beat(alm_pkg::OP_SEARCH, $urandom,   32'd0,   8'd0);

      // Random part in phases, each with its own leaning and idling.
      sent = 0;
      while (sent < 300) begin
         mood = $urandom_range(0, 2);
         calm = ($urandom_range(0, 3) == 0);
         repeat ($urandom_range(20, 60)) begin
            send_beat(pick_op(mood), pick_key(), $urandom, pick_position());
            sent++;
         end
      end
      calm = 1'b0;
      req_tvalid = 1'b0;

      while (awaiting != 0) @(negedge clock);
      repeat (300) @(negedge clock);
      if (mismatches == 0 && awaiting == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
